// ===== sv/slcl_pkg.sv =====
// Shared types, codes and constants for the serial line command LED driver.
// No dependencies; every other file refers to this package by scoped names.
package slcl_pkg;

  localparam int BUFFER_BYTES_DEF = 64;
  localparam int BLINK_W          = 16;
  localparam int LINE_LEN_W       = 6;
  localparam int QUEUE_DEPTH      = 2;  // power of two
  localparam int POS_W            = 3;  // token position, saturates at 7

  localparam logic [BLINK_W-1:0] BLINK_RESET = 16'd500;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_DEL   = 8'h7F;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  localparam logic [7:0] WORD_ON     [2] = '{8'h4F, 8'h4E};
  localparam logic [7:0] WORD_OFF    [3] = '{8'h4F, 8'h46, 8'h46};
  localparam logic [7:0] WORD_TOGGLE [6] = '{8'h54, 8'h4F, 8'h47, 8'h47, 8'h4C, 8'h45};

  localparam logic [POS_W-1:0] LEN_ON     = 3'd2;
  localparam logic [POS_W-1:0] LEN_OFF    = 3'd3;
  localparam logic [POS_W-1:0] LEN_TOGGLE = 3'd6;

  typedef enum logic [1:0] {
    OP_STORE,
    OP_ERASE,
    OP_END,
    OP_TICK
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_ECHO    = 3'd1,
    EV_ERASE   = 3'd2,
    EV_ON      = 3'd3,
    EV_OFF     = 3'd4,
    EV_TOGGLE  = 3'd5,
    EV_UNKNOWN = 3'd6,
    EV_DISCARD = 3'd7
  } event_t;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_ON     = 2'd1,
    MODE_TOGGLE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } back_state_t;

  function automatic logic [7:0] upper_case(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB);
  endfunction

endpackage

// ===== sv/slcl_front.sv =====
// Front end: accepts items and classifies them into queue operations.
// Depends on slcl_pkg (op_t, q_status_t, character codes).
module slcl_front (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  command,
  input  logic [7:0]            rx_byte,
  input  slcl_pkg::q_status_t   q_status,
  output logic                  q_push,
  output slcl_pkg::op_t         q_op
);

  assign in_stall = q_status.full;
  assign q_push   = in_valid && !q_status.full;

  always_comb begin
    q_op.data = rx_byte;
    if (command) begin
      q_op.kind = slcl_pkg::OP_TICK;
    end else if (rx_byte == slcl_pkg::CHAR_CR || rx_byte == slcl_pkg::CHAR_LF) begin
      q_op.kind = slcl_pkg::OP_END;
    end else if (rx_byte == slcl_pkg::CHAR_BS || rx_byte == slcl_pkg::CHAR_DEL) begin
      q_op.kind = slcl_pkg::OP_ERASE;
    end else begin
      q_op.kind = slcl_pkg::OP_STORE;
    end
  end

endmodule

// ===== sv/slcl_fifo.sv =====
// Short operation queue between the front end and the back end.
// Depends on slcl_pkg (op_t, q_status_t, QUEUE_DEPTH).
module slcl_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  slcl_pkg::op_t       push_op,
  input  logic                pop,
  output slcl_pkg::op_t       pop_op,
  output slcl_pkg::q_status_t status
);

  localparam int PTR_W = (slcl_pkg::QUEUE_DEPTH > 1) ? $clog2(slcl_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(slcl_pkg::QUEUE_DEPTH + 1);

  slcl_pkg::op_t    slots [slcl_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign status.full  = (fill == CNT_W'(slcl_pkg::QUEUE_DEPTH));
  assign status.empty = (fill == '0);
  assign pop_op       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== sv/slcl_back.sv =====
// Back end: line store, line evaluation walk, LED mode/blink state and result register.
// Depends on slcl_pkg (op_t, event_t, mode_t, back_state_t, word tables).
module slcl_back #(
  parameter int BUFFER_BYTES = slcl_pkg::BUFFER_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  slcl_pkg::op_t                   q_op,
  output logic                            q_pop,
  input  logic                            cfg_wr_en,
  input  logic [slcl_pkg::BLINK_W-1:0]    cfg_wr_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      event_res,
  output logic [7:0]                      echo_byte,
  output logic                            led_level,
  output logic [1:0]                      led_mode,
  output logic [slcl_pkg::LINE_LEN_W-1:0] line_length
);

  localparam int CAP    = BUFFER_BYTES - 1;
  localparam int ADDR_W = $clog2(CAP);
  localparam int CNT_W  = $clog2(BUFFER_BYTES);
  localparam int BW     = slcl_pkg::BLINK_W;
  localparam int PW     = slcl_pkg::POS_W;

  slcl_pkg::back_state_t state, state_next;

  logic [7:0]       mem [CAP];
  logic [CNT_W-1:0] count, count_next;
  slcl_pkg::mode_t  mode, mode_next;
  logic             level, level_next;
  logic [BW-1:0]    blink_cnt, blink_next, blink_inc;
  logic [BW-1:0]    blink_period;

  // line walk
  logic [CNT_W-1:0] idx;
  logic             rd_en;
  logic             rd_vld;
  logic [7:0]       rd_data;
  logic             scan_end;
  logic             in_token;
  logic [PW-1:0]    pos, last_len, p_eff, p_inc;
  logic             ok_on, ok_off, ok_tgl;
  logic             on_hit, off_hit, tgl_hit;
  logic [7:0]       uc;

  logic             out_free;
  logic             load_out;
  logic             store_wr;
  slcl_pkg::event_t ev;
  logic [7:0]       echo;
  slcl_pkg::event_t event_q;
  slcl_pkg::mode_t  mode_q;

  assign out_free  = !out_valid || !out_stall;
  assign q_pop     = (state == slcl_pkg::ST_IDLE) && q_valid && out_free;
  assign blink_inc = blink_cnt + BW'(1);

  assign rd_en    = (state == slcl_pkg::ST_SCAN) && (idx < count);
  assign scan_end = (rd_vld && rd_data == slcl_pkg::CHAR_NUL) || (!rd_vld && idx == count);

  assign uc      = slcl_pkg::upper_case(rd_data);
  assign p_eff   = in_token ? pos : '0;
  assign p_inc   = (p_eff == {PW{1'b1}}) ? p_eff : p_eff + PW'(1);
  assign on_hit  = (p_eff < slcl_pkg::LEN_ON) && (uc == slcl_pkg::WORD_ON[p_eff[0]]);
  assign off_hit = (p_eff < slcl_pkg::LEN_OFF) && (uc == slcl_pkg::WORD_OFF[p_eff[1:0]]);
  assign tgl_hit = (p_eff < slcl_pkg::LEN_TOGGLE) && (uc == slcl_pkg::WORD_TOGGLE[p_eff]);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      slcl_pkg::ST_IDLE: begin
        if (q_pop && q_op.kind == slcl_pkg::OP_END && count != '0) begin
          state_next = slcl_pkg::ST_SCAN;
        end
      end
      slcl_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = slcl_pkg::ST_DONE;
        end
      end
      slcl_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = slcl_pkg::ST_IDLE;
        end
      end
      default: state_next = slcl_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    count_next = count;
    mode_next  = mode;
    level_next = level;
    blink_next = blink_cnt;
    ev         = slcl_pkg::EV_NONE;
    echo       = 8'd0;
    load_out   = 1'b0;
    store_wr   = 1'b0;
    case (state)
      slcl_pkg::ST_IDLE: begin
        if (q_pop) begin
          case (q_op.kind)
            slcl_pkg::OP_TICK: begin
              load_out = 1'b1;
              if (mode == slcl_pkg::MODE_TOGGLE) begin
                if (blink_inc >= blink_period) begin
                  level_next = ~level;
                  blink_next = '0;
                end else begin
                  blink_next = blink_inc;
                end
              end
            end
            slcl_pkg::OP_ERASE: begin
              load_out = 1'b1;
              if (count != '0) begin
                count_next = count - CNT_W'(1);
                ev         = slcl_pkg::EV_ERASE;
              end
            end
            slcl_pkg::OP_STORE: begin
              load_out = 1'b1;
              if (count < CNT_W'(CAP)) begin
                store_wr   = 1'b1;
                count_next = count + CNT_W'(1);
                ev         = slcl_pkg::EV_ECHO;
                echo       = q_op.data;
              end else begin
                ev = slcl_pkg::EV_DISCARD;
              end
            end
            slcl_pkg::OP_END: begin
              // a non-empty line goes to the walk, the result comes from ST_DONE
              load_out = (count == '0);
            end
            default: ;
          endcase
        end
      end
      slcl_pkg::ST_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          count_next = '0;
          if (!in_token) begin
            ev = slcl_pkg::EV_NONE;
          end else if (ok_on && last_len == slcl_pkg::LEN_ON) begin
            ev         = slcl_pkg::EV_ON;
            mode_next  = slcl_pkg::MODE_ON;
            level_next = 1'b1;
          end else if (ok_off && last_len == slcl_pkg::LEN_OFF) begin
            ev         = slcl_pkg::EV_OFF;
            mode_next  = slcl_pkg::MODE_OFF;
            level_next = 1'b0;
          end else if (ok_tgl && last_len == slcl_pkg::LEN_TOGGLE) begin
            ev         = slcl_pkg::EV_TOGGLE;
            mode_next  = slcl_pkg::MODE_TOGGLE;
            blink_next = '0;
          end else begin
            ev = slcl_pkg::EV_UNKNOWN;
          end
        end
      end
      default: ;
    endcase
  end

  // line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (store_wr) begin
      mem[count[ADDR_W-1:0]] <= q_op.data;
    end
    if (rd_en) begin
      rd_data <= mem[idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= slcl_pkg::ST_IDLE;
      count        <= '0;
      mode         <= slcl_pkg::MODE_OFF;
      level        <= 1'b0;
      blink_cnt    <= '0;
      blink_period <= slcl_pkg::BLINK_RESET;
      out_valid    <= 1'b0;
      rd_vld       <= 1'b0;
      idx          <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      mode      <= mode_next;
      level     <= level_next;
      blink_cnt <= blink_next;
      rd_vld    <= rd_en;
      if (cfg_wr_en) begin
        blink_period <= cfg_wr_data;
      end
      if (state == slcl_pkg::ST_IDLE) begin
        idx <= '0;
      end else if (rd_en) begin
        idx <= idx + CNT_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // token tracking: position counts from the first non-blank byte, blanks included;
  // last_len marks the end of the last non-blank byte, so trailing blanks drop out
  always_ff @(posedge clk) begin
    if (state == slcl_pkg::ST_IDLE) begin
      in_token <= 1'b0;
      pos      <= '0;
      last_len <= '0;
      ok_on    <= 1'b1;
      ok_off   <= 1'b1;
      ok_tgl   <= 1'b1;
    end else if (state == slcl_pkg::ST_SCAN && rd_vld && rd_data != slcl_pkg::CHAR_NUL) begin
      if (!slcl_pkg::is_blank(rd_data)) begin
        in_token <= 1'b1;
        pos      <= p_inc;
        last_len <= p_inc;
        // pos ahead of last_len means a blank sits inside the token: no word has one
        ok_on    <= ok_on && on_hit && (pos == last_len);
        ok_off   <= ok_off && off_hit && (pos == last_len);
        ok_tgl   <= ok_tgl && tgl_hit && (pos == last_len);
      end else if (in_token) begin
        pos <= p_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      event_q     <= ev;
      echo_byte   <= echo;
      led_level   <= level_next;
      mode_q      <= mode_next;
      line_length <= slcl_pkg::LINE_LEN_W'(count_next);
    end
  end

  assign event_res = event_q;
  assign led_mode  = mode_q;

endmodule

// ===== sv/serial_line_command_led_driver_top.sv =====
// Top level of the serial line command LED driver: front end, operation queue, back end.
// Depends on slcl_pkg, slcl_front, slcl_fifo and slcl_back.
//
//   channel | direction | handshake             | payload
//   in      | to block  | in_valid / in_stall   | command, rx_byte
//   out     | from block| out_valid / out_stall | event_res, echo_byte, led_level,
//           |           |                       | led_mode, line_length
//   cfg     | to block  | cfg_wr_en             | cfg_wr_data (blink_period)
//
// Bytes, erases and ticks are handled in the back end as they leave the queue; a CR or LF
// ending a non-empty line starts a walk over the line store's single read port, one byte
// per cycle, that stops at the first NUL byte or after the last stored byte.
// A two-entry queue lets the front end keep accepting, until it fills, while the back end walks a line.
// Synchronous active-high reset clears control state; the line store is not cleared.
// The result register holds while out_stall is high and a new item may still enter the queue meanwhile.
module serial_line_command_led_driver_top #(
  parameter int BUFFER_BYTES = slcl_pkg::BUFFER_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            command,
  input  logic [7:0]                      rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      event_res,
  output logic [7:0]                      echo_byte,
  output logic                            led_level,
  output logic [1:0]                      led_mode,
  output logic [slcl_pkg::LINE_LEN_W-1:0] line_length,
  input  logic                            cfg_wr_en,
  input  logic [slcl_pkg::BLINK_W-1:0]    cfg_wr_data
);

  slcl_pkg::q_status_t q_status;
  slcl_pkg::op_t       push_op;
  slcl_pkg::op_t       pop_op;
  logic                q_push;
  logic                q_pop;

  slcl_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .rx_byte  (rx_byte),
    .q_status (q_status),
    .q_push   (q_push),
    .q_op     (push_op)
  );

  slcl_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (push_op),
    .pop     (q_pop),
    .pop_op  (pop_op),
    .status  (q_status)
  );

  slcl_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (!q_status.empty),
    .q_op        (pop_op),
    .q_pop       (q_pop),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_res   (event_res),
    .echo_byte   (echo_byte),
    .led_level   (led_level),
    .led_mode    (led_mode),
    .line_length (line_length)
  );

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full || q_pop)
    else $error("queue push while full");

  a_echo_only_on_echo: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != slcl_pkg::EV_ECHO |-> echo_byte == 8'd0)
    else $error("echo byte set without echo event");

  a_on_off_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == slcl_pkg::EV_ON |-> led_level && led_mode == slcl_pkg::MODE_ON)
    else $error("ON result without lit steady LED");

  a_line_cleared: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == slcl_pkg::EV_ON || event_res == slcl_pkg::EV_OFF ||
                  event_res == slcl_pkg::EV_TOGGLE || event_res == slcl_pkg::EV_UNKNOWN)
    |-> line_length == '0)
    else $error("line store not emptied after a line");

endmodule
